// File: src/clcf_pkg.sv
// clcf_pkg: shared types and constants for the command line character filter
// no dependencies; imported by command_line_char_filter_top
package clcf_pkg;

	// line buffer size, derived fill width, fixed position width and fill limit
	localparam int LINE_SIZE  = 96;
	localparam int FILL_W     = $clog2(LINE_SIZE);
	localparam int POS_W      = 7;
	localparam logic [FILL_W-1:0] FILL_LIMIT = FILL_W'(LINE_SIZE - 1);

	// characters with a meaning of their own
	localparam logic [7:0] CH_LF        = 8'h0A;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_BACKSPACE = 8'h08;
	localparam logic [7:0] CH_SEMICOLON = 8'h3B;
	localparam logic [7:0] CH_LPAREN    = 8'h28;
	localparam logic [7:0] CH_RPAREN    = 8'h29;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE     = 8'h22;

	// configuration register indexes
	localparam logic CFG_PAREN_COMMENTS = 1'b0;
	localparam logic CFG_QUOTED_STRINGS = 1'b1;

	// parse mode; escape codes are the mode before the escape plus four
	typedef enum logic [2:0] {
		MODE_NORMAL     = 3'd0,
		MODE_EOL        = 3'd1,
		MODE_QUOTED     = 3'd2,
		MODE_PAREN      = 3'd3,
		MODE_ESC_NORMAL = 3'd4,
		MODE_ESC_EOL    = 3'd5,
		MODE_ESC_QUOTED = 3'd6,
		MODE_ESC_PAREN  = 3'd7
	} mode_t;

	// buffer action reported per byte
	typedef enum logic [2:0] {
		ACT_NONE  = 3'd0,
		ACT_STORE = 3'd1,
		ACT_ERASE = 3'd2,
		ACT_LINE  = 3'd3,
		ACT_EMPTY = 3'd4
	} action_t;

endpackage

// File: src/command_line_char_filter_top.sv
// command_line_char_filter_top: byte-by-byte command line builder
// depends on clcf_pkg for character codes, mode and action types
//
// Takes one received byte per transfer and gives one buffer action per byte:
// nothing, store a byte, erase a byte, line complete (position holds the
// length, out_byte is the zero terminator) or empty line. Semicolon comments,
// optional parenthesised comments, optional quoted strings, backslash escapes,
// backspace and line overflow at LINE_SIZE-1 bytes are handled here. A byte
// passes an input register and then the parse logic into the result register;
// one byte is taken in every cycle as long as the result side does not stall.
// Configuration writes belong to idle periods.
module command_line_char_filter_top
	import clcf_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	// configuration write port
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic             cfg_data,
	// input channel
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       in_byte,
	// result channel
	output logic             out_valid,
	input  logic             out_stall,
	output logic [2:0]       action,
	output logic [POS_W-1:0] position,
	output logic [7:0]       out_byte
);

	logic              paren_on_q;
	logic              quoted_on_q;
	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              out_valid_q;
	action_t           action_q;
	logic [POS_W-1:0]  position_q;
	logic [7:0]        out_byte_q;
	mode_t             mode_q;
	logic [FILL_W-1:0] fill_q;
	logic              advance;
	logic              in_take;
	mode_t             mode_d;
	mode_t             mode_mid;
	logic [FILL_W-1:0] fill_d;
	action_t           act_d;
	logic [FILL_W-1:0] pos_d;
	logic [7:0]        obyte_d;
	logic              fall_through;
	logic [FILL_W-1:0] fill_inc;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paren_on_q  <= 1'b0;
			quoted_on_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_PAREN_COMMENTS)
				paren_on_q <= cfg_data;
			if (cfg_index == CFG_QUOTED_STRINGS)
				quoted_on_q <= cfg_data;
		end
	end

	// handshake: stage 1 moves on when the result register is free or drained
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// end of line, then mode escape/comment/quote rules, then backspace or store
	always_comb begin
		mode_mid     = mode_q;
		mode_d       = mode_q;
		fill_d       = fill_q;
		act_d        = ACT_NONE;
		pos_d        = '0;
		obyte_d      = '0;
		fall_through = 1'b0;
		fill_inc     = fill_q + 1'b1;

		priority if (byte_s1 == CH_LF || byte_s1 == CH_CR) begin
			// end of line in any mode
			mode_d = MODE_NORMAL;
			fill_d = '0;
			if (fill_q != '0) begin
				act_d = ACT_LINE;
				pos_d = fill_q;
			end else begin
				act_d = ACT_EMPTY;
			end
		end else if (mode_q == MODE_EOL) begin
			mode_d = MODE_EOL;
		end else if (mode_q == MODE_PAREN) begin
			if (byte_s1 == CH_RPAREN)
				mode_d = MODE_NORMAL;
		end else if (mode_q[2]) begin
			// escaped byte: back to the mode before the escape
			mode_mid     = mode_t'({1'b0, mode_q[1:0]});
			fall_through = 1'b1;
		end else if (byte_s1 == CH_BACKSLASH) begin
			mode_mid     = mode_t'({1'b1, mode_q[1:0]});
			mode_d       = mode_mid;
			// inside quotes the backslash itself is kept
			fall_through = (mode_q == MODE_QUOTED);
		end else if (mode_q == MODE_QUOTED) begin
			if (byte_s1 == CH_QUOTE)
				mode_mid = MODE_NORMAL;
			fall_through = 1'b1;
		end else if (quoted_on_q && byte_s1 == CH_QUOTE) begin
			mode_mid     = MODE_QUOTED;
			fall_through = 1'b1;
		end else if (byte_s1 == CH_SEMICOLON) begin
			mode_d = MODE_EOL;
		end else if (paren_on_q && byte_s1 == CH_LPAREN) begin
			mode_d = MODE_PAREN;
		end else begin
			fall_through = 1'b1;
		end

		// buffer update for bytes that reach the line
		if (fall_through) begin
			mode_d = mode_mid;
			if (byte_s1 == CH_BACKSPACE) begin
				if (fill_q != '0) begin
					fill_d = fill_q - 1'b1;
					act_d  = ACT_ERASE;
					pos_d  = fill_q - 1'b1;
				end
			end else begin
				fill_d  = fill_inc;
				act_d   = ACT_STORE;
				pos_d   = fill_q;
				obyte_d = byte_s1;
				// overflow skips the rest of the line
				if (fill_inc >= FILL_LIMIT)
					mode_d = MODE_EOL;
			end
		end
	end

	// input register, parse state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			mode_q      <= MODE_NORMAL;
			fill_q      <= '0;
		end else begin
			// stage 1 fills on a transfer, empties when its byte moves on
			if (in_take)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				out_valid_q <= valid_s1;
			if (advance && valid_s1) begin
				mode_q <= mode_d;
				fill_q <= fill_d;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_take)
			byte_s1 <= in_byte;
		if (advance && valid_s1) begin
			action_q   <= act_d;
			position_q <= POS_W'(pos_d);
			out_byte_q <= obyte_d;
		end
	end

	assign out_valid = out_valid_q;
	assign action    = action_q;
	assign position  = position_q;
	assign out_byte  = out_byte_q;

endmodule

// File: tb/command_line_char_filter_top_test.sv
// command_line_char_filter_top_test: self-checking bench for the command line character filter
// depends on clcf_pkg and command_line_char_filter_top; predicts every buffer action per byte
// and compares it field by field while both sides idle and stall at random
module command_line_char_filter_top_test;
	import clcf_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 4;

	typedef struct packed {
		action_t               act;
		logic [POS_W-1:0]      pos;
		logic [7:0]            data;
	} buffer_op_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic             cfg_index = 1'b0;
	logic             cfg_data = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [7:0]       in_byte = 8'h00;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [2:0]       action;
	logic [POS_W-1:0] position;
	logic [7:0]       out_byte;

	// shadow of the block state and its registers
	mode_t       line_mode = MODE_NORMAL;
	int          fill_count = 0;
	logic        paren_on = 1'b0;
	logic        quoted_on = 1'b0;

	buffer_op_t  pending_ops[$];
	int          mismatch_count = 0;
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int          hold_request = 0;
	int          hold_left = 0;
	int          quiet_cycles = 0;

	command_line_char_filter_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.action    (action),
		.position  (position),
		.out_byte  (out_byte)
	);

	// clock, period 8
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// buffer action for one received byte, advancing the shadow state
	function automatic buffer_op_t next_buffer_op(input logic [7:0] c);
		buffer_op_t op;
		op.act  = ACT_NONE;
		op.pos  = '0;
		op.data = '0;
		// end of line wins in every mode
		if (c == CH_LF || c == CH_CR) begin
			line_mode = MODE_NORMAL;
			if (fill_count != 0) begin
				op.act = ACT_LINE;
				op.pos = POS_W'(fill_count);
				fill_count = 0;
			end else begin
				op.act = ACT_EMPTY;
			end
			return op;
		end
		if (line_mode == MODE_EOL)
			return op;
		if (line_mode == MODE_PAREN) begin
			if (c == CH_RPAREN)
				line_mode = MODE_NORMAL;
			return op;
		end
		// escapes, strings and comment starts
		if (line_mode >= MODE_ESC_NORMAL) begin
			line_mode = mode_t'(line_mode - 3'd4);
		end else if (c == CH_BACKSLASH) begin
			line_mode = mode_t'(line_mode + 3'd4);
			if (line_mode == MODE_ESC_NORMAL)
				return op;
		end else if (line_mode == MODE_QUOTED) begin
			if (c == CH_QUOTE)
				line_mode = MODE_NORMAL;
		end else if (quoted_on && c == CH_QUOTE) begin
			line_mode = MODE_QUOTED;
		end else if (c == CH_SEMICOLON) begin
			line_mode = MODE_EOL;
			return op;
		end else if (paren_on && c == CH_LPAREN) begin
			line_mode = MODE_PAREN;
			return op;
		end
		// backspace erases, anything else is stored
		if (c == CH_BACKSPACE) begin
			if (fill_count != 0) begin
				fill_count--;
				op.act = ACT_ERASE;
				op.pos = POS_W'(fill_count);
			end
			return op;
		end
		op.act  = ACT_STORE;
		op.pos  = POS_W'(fill_count);
		op.data = c;
		fill_count++;
		if (fill_count >= LINE_SIZE - 1)
			line_mode = MODE_EOL;
		return op;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: %s: got %0d, want %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	// one byte transfer; valid stays high after acceptance until the next call decides
	task automatic send_byte(input logic [7:0] b);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_ops.push_back(next_buffer_op(b));
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// sender pauses until every pending action has come back
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_ops.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_PAREN_COMMENTS)
			paren_on = val;
		else
			quoted_on = val;
	endtask

	task automatic configure(input logic paren, input logic quoted);
		settle();
		write_reg(CFG_PAREN_COMMENTS, paren);
		write_reg(CFG_QUOTED_STRINGS, quoted);
	endtask

	// mostly printable, often a character with a meaning, sometimes any byte
	function automatic logic [7:0] pick_char();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 50)
			return 8'($urandom_range(8'h7E, 8'h20));
		if (roll < 90) begin
			case ($urandom_range(5))
				0: return CH_SEMICOLON;
				1: return CH_LPAREN;
				2: return CH_RPAREN;
				3: return CH_BACKSLASH;
				4: return CH_QUOTE;
				default: return CH_BACKSPACE;
			endcase
		end
		return 8'($urandom_range(255));
	endfunction

	// terminated lines with random content, a few long enough to overflow, plus stray bytes
	task automatic send_random_lines(input int unsigned budget);
		int unsigned sent;
		int unsigned len;
		sent = 0;
		while (sent < budget) begin
			if ($urandom_range(9) == 0) begin
				send_byte(8'($urandom_range(255)));
				sent++;
			end else begin
				len = ($urandom_range(15) == 0) ? $urandom_range(110, 85) : $urandom_range(20);
				for (int unsigned i = 0; i < len; i++)
					send_byte(pick_char());
				send_byte($urandom_range(1) ? CH_CR : CH_LF);
				sent += len + 1;
			end
		end
	endtask

	task automatic random_phase(input int unsigned idle, input int unsigned stall,
			input logic paren, input logic quoted, input int unsigned budget);
		configure(paren, quoted);
		send_idle_pct = idle;
		stall_pct     = stall;
		send_random_lines(budget);
	endtask

	// empty lines, backspace on nothing, byte extremes, erase and line length
	task automatic test_basic_lines();
		send_idle_pct = 20;
		stall_pct     = 20;
		send_byte(CH_LF);
		send_byte(CH_CR);
		send_byte(CH_BACKSPACE);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(CH_BACKSPACE);
		send_text("G1");
		send_byte(CH_CR);
	endtask

	// semicolon comments, parentheses and quotes with the registers off and on
	task automatic test_comments();
		send_text("G;x(");
		send_byte(CH_LF);
		send_text("(a\"");
		send_byte(CH_LF);
		configure(1'b1, 1'b1);
		send_text("(a;)b\";(\"");
		send_byte(CH_LF);
		send_text("(x");
		send_byte(CH_LF);
		send_text("c");
		send_byte(CH_LF);
	endtask

	// backslash drops in normal mode, stays inside quotes, cannot stop backspace or newline
	task automatic test_escapes();
		configure(1'b0, 1'b0);
		send_text("\\a\\;");
		send_byte(CH_BACKSLASH);
		send_byte(CH_BACKSPACE);
		send_byte(CH_BACKSLASH);
		send_byte(CH_LF);
		configure(1'b0, 1'b1);
		send_text("\"\\\"b\"\\q");
		send_byte(CH_CR);
		send_text("\"\\");
		send_byte(CH_LF);
	endtask

	// a string or comment entered before the register is cleared runs to its close
	task automatic test_register_cleared_inside();
		configure(1'b0, 1'b1);
		send_text("\"a");
		configure(1'b0, 1'b0);
		send_text(";\";x");
		send_byte(CH_LF);
		configure(1'b1, 1'b0);
		send_text("k(");
		configure(1'b0, 1'b0);
		send_text("z)y(");
		send_byte(CH_LF);
	endtask

	// line fills to LINE_SIZE-1 bytes, the rest is skipped, backspace included
	task automatic test_line_overflow();
		for (int i = 0; i < LINE_SIZE + 2; i++)
			send_byte(8'(8'h30 + i % 10));
		send_byte(CH_BACKSPACE);
		send_byte(CH_LF);
	endtask

	task automatic test_random_traffic();
		random_phase(0, 0, 1'b0, 1'b0, 450);
		random_phase(85, 0, 1'b1, 1'b0, 350);
		random_phase(0, 85, 1'b0, 1'b1, 350);
		random_phase(37, 37, 1'b1, 1'b1, 350);
	endtask

	// receiver holds off long enough for the block to stall its input
	task automatic test_backpressure_fill();
		configure(1'b1, 1'b1);
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_request  = 300;
		send_random_lines(60);
		settle();
		send_idle_pct = 10;
		stall_pct     = 10;
		send_random_lines(80);
	endtask

	// receiver stall, with an optional long hold-off counted here
	always @(negedge clk) begin
		if (hold_request != 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// compare each result transfer with the oldest pending action
	always @(posedge clk) begin
		buffer_op_t want;
		if (out_valid && !out_stall) begin
			if (pending_ops.size() == 0) begin
				report_mismatch("result with nothing pending, action", action, -1);
			end else begin
				want = pending_ops.pop_front();
				if (action !== want.act)
					report_mismatch("action", action, want.act);
				if (position !== want.pos)
					report_mismatch("position", position, want.pos);
				if (out_byte !== want.data)
					report_mismatch("out_byte", out_byte, want.data);
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout after %0d cycles without a transfer", quiet_cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		test_basic_lines();
		test_comments();
		test_escapes();
		test_register_cleared_inside();
		test_line_overflow();
		test_random_traffic();
		test_backpressure_fill();
		settle();
		repeat (8) @(posedge clk);
		if (pending_ops.size() != 0)
			report_mismatch("actions never returned", 0, pending_ops.size());
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
